// ===== design/assert_macros.svh =====
// Assertion helpers included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cw_pkg.sv =====
`timescale 1ns / 1ps
package cw_pkg;
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_KERNEL  = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int LINE_SLOTS  = MAX_KERNEL - 1;
  localparam int NUM_TAPS    = MAX_KERNEL * MAX_KERNEL;
  localparam int COL_W       = 6;
  localparam int SLOT_W      = 2;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int RSUM_W      = PROD_W + 3;
  localparam int VALUE_W     = 40;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  // word command codes
  typedef enum logic {
    CMD_WEIGHT = 1'b0,
    CMD_PIXEL  = 1'b1
  } cmd_t;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KROWS  = 2'd2;
  localparam logic [1:0] REG_KCOLS  = 2'd3;

  // per-word tag carried down the pipeline
  typedef struct packed {
    logic             emit;
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;
endpackage

// ===== design/cw_line_buf.sv =====
`timescale 1ns / 1ps
module cw_line_buf (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [cw_pkg::COL_W-1:0]               addr,
  input  logic                                   wr_en,
  input  logic [cw_pkg::SLOT_W-1:0]              wr_slot,
  input  cw_pkg::sample_t                        wr_data,
  output cw_pkg::sample_t [cw_pkg::LINE_SLOTS-1:0] rd_data
);
  import cw_pkg::*;

  // one bank per stored row, read-first
  for (genvar b = 0; b < LINE_SLOTS; b++) begin : g_bank
    sample_t mem [MAX_WIDTH];
    sample_t rd_r;
    always_ff @(posedge clk) begin
      if (rd_en) rd_r <= mem[addr];
      if (wr_en && (wr_slot == SLOT_W'(b))) mem[addr] <= wr_data;
    end
    assign rd_data[b] = rd_r;
  end
endmodule

// ===== design/cw_cell.sv =====
`timescale 1ns / 1ps
module cw_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic            adv,
  input  cw_pkg::sample_t pix_in,
  input  cw_pkg::sample_t weight,
  output cw_pkg::sample_t pix_out,
  output cw_pkg::prod_t   prod
);
  import cw_pkg::*;

  sample_t pix_r;
  prod_t   prod_r;

  // window tap: takes the pixel from its right neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (shift_en) begin
      pix_r <= pix_in;
    end
  end

  // registered tap product
  always_ff @(posedge clk) begin
    if (adv) prod_r <= pix_r * weight;
  end

  assign pix_out = pix_r;
  assign prod    = prod_r;
endmodule

// ===== design/conv2d_valid_window.sv =====
`timescale 1ns / 1ps
// Streaming 2-D valid-mode cross-correlation over a window of up to 5x5.
// Input words: in_tuser selects the kind (0 loads a kernel weight at
// weight_index, 1 pushes one image pixel in raster order). Weights should be
// loaded before the pixels they apply to; a load takes effect in order.
// Config port: cfg_index 0..3 = image width, image height, kernel rows,
// kernel cols; write only while no words are in flight. cfg_ready is
// always high.
// Output words: one per pixel whose window lies fully inside the image,
// carrying the 40-bit signed integer sum (Q40.0), result row and column; out_tlast marks the
// final result of the image.
// Pipeline: stage 1 registers with the line buffer read, window shift into the
// tap cells, tap product registers, row sums, final sum in the output register.
// Throughput: one word per cycle unless the output stalls; the 25 tap cells
// multiply in parallel and the line buffer banks take one read and one write per cycle.
// Reset: weights, window, position counters cleared; geometry back to 32x32
// with a 5x5 kernel. Line buffer contents are unset until written.
// When out_tready is low with a result waiting, the whole pipeline holds and
// in_tready drops in the same cycle.
module conv2d_valid_window (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [4:0] weight_index, [20:5] sample, rest zero
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [39:0] conv_value, [45:40] out_row, [51:46] out_col
  output logic        out_tlast,  // last_of_image
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import cw_pkg::*;

  `include "assert_macros.svh"

  // configuration registers
  logic [6:0] width_r, height_r;
  logic [2:0] krows_r, kcols_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd32;
      height_r <= 7'd32;
      krows_r  <= 3'd5;
      kcols_r  <= 3'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_KROWS:  krows_r  <= cfg_data[2:0];
        REG_KCOLS:  kcols_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [6:0] w_eff, h_eff;
  logic [2:0] kr_eff, kc_eff;
  always_comb begin
    w_eff  = (width_r == '0) ? 7'd1 : ((width_r > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_r);
    h_eff  = (height_r == '0) ? 7'd1 :
             ((height_r > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_r);
    kr_eff = (krows_r == '0) ? 3'd1 : ((krows_r > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : krows_r);
    kc_eff = (kcols_r == '0) ? 3'd1 : ((kcols_r > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kcols_r);
  end

  // global advance: all stages move together
  logic adv, acc_in, is_pix;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign acc_in    = in_tvalid && adv;
  assign is_pix    = (cmd_t'(in_tuser) == CMD_PIXEL);

  logic [4:0] in_idx;
  sample_t    in_sample;
  assign in_idx    = in_tdata[4:0];
  assign in_sample = in_tdata[20:5];

  // position counters and result tagging
  logic [COL_W-1:0] prow_r, pcol_r;
  logic [6:0]       row_p1, col_p1;
  logic             in_image, end_row, end_img;
  meta_t            meta0;
  assign row_p1   = {1'b0, prow_r} + 7'd1;
  assign col_p1   = {1'b0, pcol_r} + 7'd1;
  assign in_image = ({1'b0, prow_r} < h_eff) && ({1'b0, pcol_r} < w_eff);
  assign end_row  = col_p1 >= w_eff;
  assign end_img  = end_row && (row_p1 >= h_eff);

  always_comb begin
    meta0.emit = is_pix && in_image && (row_p1 >= {4'd0, kr_eff}) &&
                 (col_p1 >= {4'd0, kc_eff});
    meta0.row  = COL_W'(row_p1 - {4'd0, kr_eff});
    meta0.col  = COL_W'(col_p1 - {4'd0, kc_eff});
    meta0.last = end_img;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prow_r <= '0;
      pcol_r <= '0;
    end else if (acc_in && is_pix) begin
      if (end_row) begin
        pcol_r <= '0;
        prow_r <= end_img ? '0 : COL_W'(row_p1);
      end else begin
        pcol_r <= COL_W'(col_p1);
      end
    end
  end

  // line buffer: read all stored rows at this column, write the new pixel
  sample_t [LINE_SLOTS-1:0] lb_rd;
  cw_line_buf u_lbuf (
    .clk     (clk),
    .rd_en   (adv),
    .addr    (pcol_r),
    .wr_en   (acc_in && is_pix),
    .wr_slot (prow_r[SLOT_W-1:0]),
    .wr_data (in_sample),
    .rd_data (lb_rd)
  );

  // stage 1 registers
  logic             s1_vld_r, s1_pix_r;
  logic [4:0]       s1_idx_r;
  sample_t          s1_smp_r;
  logic [COL_W-1:0] s1_row_r;
  meta_t            s1_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r  <= is_pix;
      s1_idx_r  <= in_idx;
      s1_smp_r  <= in_sample;
      s1_row_r  <= prow_r;
      s1_meta_r <= meta0;
    end
  end

  // kernel weights, written in order with the pixel stream
  sample_t weights_r [NUM_TAPS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAPS; i++) weights_r[i] <= '0;
    end else if (adv && s1_vld_r && !s1_pix_r && (s1_idx_r < 5'(NUM_TAPS))) begin
      weights_r[s1_idx_r] <= s1_smp_r;
    end
  end

  // new window column, top row first
  sample_t col_val [MAX_KERNEL];
  always_comb begin
    for (int wr = 0; wr < MAX_KERNEL - 1; wr++) begin
      if (s1_row_r >= COL_W'(MAX_KERNEL - 1 - wr))
        col_val[wr] = lb_rd[SLOT_W'(s1_row_r - COL_W'(MAX_KERNEL - 1 - wr))];
      else
        col_val[wr] = '0;
    end
    col_val[MAX_KERNEL-1] = s1_smp_r;
  end

  logic shift_en;
  assign shift_en = adv && s1_vld_r && s1_pix_r;

  // stage 2: tap cells
  prod_t prods [MAX_KERNEL][MAX_KERNEL];
  for (genvar wr = 0; wr < MAX_KERNEL; wr++) begin : g_row
    sample_t pix [MAX_KERNEL+1];
    assign pix[MAX_KERNEL] = col_val[wr];
    for (genvar wc = 0; wc < MAX_KERNEL; wc++) begin : g_col
      logic [2:0] ri, ci;
      logic       used;
      logic [4:0] widx;
      sample_t    wsel;
      // tap -> kernel position, zero weight for taps outside the kernel
      assign ri   = 3'(wr) + kr_eff - 3'(MAX_KERNEL);
      assign ci   = 3'(wc) + kc_eff - 3'(MAX_KERNEL);
      assign used = ({1'b0, 3'(wr)} + {1'b0, kr_eff} >= 4'(MAX_KERNEL)) &&
                    ({1'b0, 3'(wc)} + {1'b0, kc_eff} >= 4'(MAX_KERNEL));
      assign widx = 5'(ri) * 5'(MAX_KERNEL) + 5'(ci);
      assign wsel = (used && (widx < 5'(NUM_TAPS))) ? weights_r[widx] : '0;
      cw_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .adv      (adv),
        .pix_in   (pix[wc+1]),
        .weight   (wsel),
        .pix_out  (pix[wc]),
        .prod     (prods[wr][wc])
      );
    end
  end

  logic  s2_vld_r;
  meta_t s2_meta_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r && s1_meta_r.emit;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) s2_meta_r <= s1_meta_r;
  end

  // tag follows the window into the cell product registers
  logic  s2p_vld_r;
  meta_t s2p_meta_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2p_vld_r <= 1'b0;
    end else if (adv) begin
      s2p_vld_r <= s2_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) s2p_meta_r <= s2_meta_r;
  end

  // stage 3: row sums
  logic signed [RSUM_W-1:0] rsum_r [MAX_KERNEL];
  logic signed [RSUM_W-1:0] rsum_nxt [MAX_KERNEL];
  always_comb begin
    for (int r = 0; r < MAX_KERNEL; r++) begin
      rsum_nxt[r] = '0;
      for (int c = 0; c < MAX_KERNEL; c++)
        rsum_nxt[r] = rsum_nxt[r] + RSUM_W'(prods[r][c]);
    end
  end

  logic  s3_vld_r;
  meta_t s3_meta_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2p_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_meta_r <= s2p_meta_r;
      for (int r = 0; r < MAX_KERNEL; r++) rsum_r[r] <= rsum_nxt[r];
    end
  end

  // stage 4: output register
  logic signed [VALUE_W-1:0] total_nxt, val_r;
  meta_t                     out_meta_r;
  logic                      out_vld_r;
  always_comb begin
    total_nxt = '0;
    for (int r = 0; r < MAX_KERNEL; r++) total_nxt = total_nxt + VALUE_W'(rsum_r[r]);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s3_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      val_r      <= total_nxt;
      out_meta_r <= s3_meta_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_meta_r.col, out_meta_r.row, val_r};
  assign out_tlast  = out_meta_r.last;

  // checks
  `CW_ASSERT_NXT(a_stall_holds_s1, out_tvalid && !out_tready, $stable(s1_vld_r), "s1 moved in stall")
  `CW_ASSERT_NXT(a_row_wrap, acc_in && is_pix && end_row, pcol_r == '0, "column did not wrap")
  `CW_ASSERT_IMP(a_no_emit_load, s1_vld_r && !s1_pix_r, !s1_meta_r.emit, "load tagged as result")
endmodule

// ===== bench/conv2d_valid_window_tb.sv =====
`timescale 1ns / 1ps
module conv2d_valid_window_tb;
  import cw_pkg::*;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [COL_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               last;
  } conv_result_t;

  // Window sum predictor plus queue of pending results
  class conv_scoreboard;
    logic [6:0]   reg_width, reg_height;
    logic [2:0]   reg_krows, reg_kcols;
    sample_t      weights [NUM_TAPS];
    sample_t      line_mem [LINE_SLOTS*MAX_WIDTH];
    sample_t      window [MAX_KERNEL][MAX_KERNEL];
    int           pix_row, pix_col;
    conv_result_t pending [$];
    int           errors;

    function new();
      reg_width  = 7'd32;
      reg_height = 7'd32;
      reg_krows  = 3'd5;
      reg_kcols  = 3'd5;
      foreach (weights[i]) weights[i] = '0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (window[r, c]) window[r][c] = '0;
      pix_row = 0;
      pix_col = 0;
      errors = 0;
    endfunction

    function int clamp(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] data);
      case (idx)
        REG_WIDTH:  reg_width  = data;
        REG_HEIGHT: reg_height = data;
        REG_KROWS:  reg_krows  = data[2:0];
        REG_KCOLS:  reg_kcols  = data[2:0];
        default: ;
      endcase
    endfunction

    // Called for each accepted input word
    function void note_word(cmd_t cmd, logic [4:0] idx, sample_t s);
      int w, h, kr, kc, d;
      sample_t col_vals [MAX_KERNEL];
      logic end_row, end_img;
      longint acc;
      conv_result_t res;
      if (cmd == CMD_WEIGHT) begin
        if (idx < NUM_TAPS) weights[idx] = s;
        return;
      end
      w  = clamp(reg_width, MAX_WIDTH);
      h  = clamp(reg_height, MAX_HEIGHT);
      kr = clamp(reg_krows, MAX_KERNEL);
      kc = clamp(reg_kcols, MAX_KERNEL);
      // new column: rows above the image read as zero
      for (int r = 0; r < MAX_KERNEL; r++) begin
        d = MAX_KERNEL - 1 - r;
        if (d == 0) col_vals[r] = s;
        else if (pix_row >= d && pix_col < MAX_WIDTH)
          col_vals[r] = line_mem[((pix_row - d) % LINE_SLOTS)*MAX_WIDTH + pix_col];
        else col_vals[r] = '0;
      end
      if (pix_col < MAX_WIDTH) line_mem[(pix_row % LINE_SLOTS)*MAX_WIDTH + pix_col] = s;
      for (int r = 0; r < MAX_KERNEL; r++) begin
        for (int c = 0; c < MAX_KERNEL - 1; c++) window[r][c] = window[r][c+1];
        window[r][MAX_KERNEL-1] = col_vals[r];
      end
      end_row = (pix_col + 1 >= w);
      end_img = end_row && (pix_row + 1 >= h);
      if (pix_row < h && pix_col < w && pix_row + 1 >= kr && pix_col + 1 >= kc) begin
        acc = 0;
        for (int i = 0; i < kr; i++)
          for (int j = 0; j < kc; j++)
            acc += longint'(window[MAX_KERNEL-kr+i][MAX_KERNEL-kc+j]) *
                   longint'(weights[i*MAX_KERNEL+j]);
        res.value = acc[VALUE_W-1:0];
        res.row   = COL_W'(pix_row + 1 - kr);
        res.col   = COL_W'(pix_col + 1 - kc);
        res.last  = end_img;
        pending.push_back(res);
      end
      if (end_row) begin
        pix_col = 0;
        pix_row = end_img ? 0 : pix_row + 1;
      end else begin
        pix_col = pix_col + 1;
      end
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("error: %s", what);
    endfunction

    // Called for each accepted output word
    function void check_result(conv_result_t got);
      conv_result_t exp;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result value=%h row=%0d col=%0d",
                       got.value, got.row, got.col));
        return;
      end
      exp = pending.pop_front();
      if (got.value !== exp.value)
        flag($sformatf("value exp %h got %h", exp.value, got.value));
      if (got.row !== exp.row)
        flag($sformatf("row exp %0d got %0d", exp.row, got.row));
      if (got.col !== exp.col)
        flag($sformatf("col exp %0d got %0d", exp.col, got.col));
      if (got.last !== exp.last)
        flag($sformatf("last exp %b got %b", exp.last, got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [4:0] weight_index, [20:5] sample
  logic        in_tuser = 1'b0; // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // [39:0] conv_value, [45:40] out_row, [51:46] out_col
  logic        out_tlast;       // last_of_image
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  conv_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int words_sent = 0;

  conv2d_valid_window dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver backpressure
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  // Output monitor
  always @(posedge clk) begin
    conv_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[39:0];
      got.row   = out_tdata[45:40];
      got.col   = out_tdata[51:46];
      got.last  = out_tlast;
      sb.check_result(got);
    end
  end

  function sample_t pick_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Send one word; entered and left at a falling edge
  task send_word(cmd_t cmd, logic [4:0] idx, sample_t s);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, s, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, idx, s);
    words_sent++;
    @(negedge clk);
  endtask

  task send_pixel(sample_t s);
    send_word(CMD_PIXEL, 5'(($urandom() & 32'h1F)), s);
  endtask

  // One write, then valid is dropped before the next write
  task cfg_write(logic [1:0] idx, logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every result is back, then let the pipe empty
  task drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Send pixels until the image position wraps back to the origin
  task finish_image();
    do send_pixel(pick_sample()); while (sb.pix_row != 0 || sb.pix_col != 0);
  endtask

  task random_geometry();
    logic [6:0] w, h;
    if ($urandom_range(9) == 0) begin
      w = ($urandom_range(1)) ? 7'd64 : 7'($urandom_range(65, 127));
      h = 7'($urandom_range(0, 6));
    end else begin
      w = 7'($urandom_range(0, 12));
      h = 7'($urandom_range(0, 10));
    end
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_KROWS, 7'($urandom_range(0, 7)));
    cfg_write(REG_KCOLS, 7'($urandom_range(0, 7)));
  endtask

  task random_weights();
    int n;
    n = ($urandom_range(3) == 0) ? 25 : $urandom_range(0, 6);
    for (int i = 0; i < n; i++)
      send_word(CMD_WEIGHT, (n == 25) ? 5'(i) : 5'($urandom_range(0, 31)), pick_sample());
  endtask

  task run_phase(int s_idle, int r_idle, int quota);
    int stop_at;
    bit cut_done;
    send_idle = s_idle;
    recv_idle = r_idle;
    stop_at = words_sent + quota;
    cut_done = 0;
    while (words_sent < stop_at) begin
      random_geometry();
      random_weights();
      if (!cut_done && sb.clamp(sb.reg_width, MAX_WIDTH) > 3 &&
          sb.clamp(sb.reg_height, MAX_HEIGHT) > 3) begin
        // geometry shrinks partway through an image
        cut_done = 1;
        repeat (2 * sb.clamp(sb.reg_width, MAX_WIDTH) + 2) send_pixel(pick_sample());
        drain();
        if ($urandom_range(1)) cfg_write(REG_WIDTH, 7'd1);
        else cfg_write(REG_HEIGHT, 7'd2);
      end
      finish_image();
      drain();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 3x3 image, 2x2 kernel with extreme weights
    cfg_write(REG_WIDTH, 7'd3);
    cfg_write(REG_HEIGHT, 7'd3);
    cfg_write(REG_KROWS, 7'd2);
    cfg_write(REG_KCOLS, 7'd2);
    send_word(CMD_WEIGHT, 5'd0, 16'sh7FFF);
    send_word(CMD_WEIGHT, 5'd1, 16'sh8000);
    send_word(CMD_WEIGHT, 5'd5, 16'sh8000);
    send_word(CMD_WEIGHT, 5'd6, 16'sh7FFF);
    send_word(CMD_WEIGHT, 5'd24, 16'sh0001);
    send_word(CMD_WEIGHT, 5'd31, 16'sh7FFF);  // out of range, dropped
    send_pixel(16'sh7FFF); send_pixel(16'sh8000); send_pixel(16'sh7FFF);
    send_pixel(16'sh8000); send_pixel(16'sh7FFF); send_pixel(16'sh8000);
    send_pixel(16'sh8000); send_pixel(16'sh8000); send_pixel(16'sh0000);
    drain();
    // kernel larger than the image: no results
    cfg_write(REG_WIDTH, 7'd2);
    cfg_write(REG_HEIGHT, 7'd2);
    cfg_write(REG_KROWS, 7'd3);
    repeat (4) send_pixel(16'sh7FFF);
    drain();

    run_phase(26, 84, 570);
    run_phase(84, 26, 570);
    run_phase(0, 0, 570);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("conv2d_valid_window: match");
    end else begin
      $display("conv2d_valid_window: mismatch");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("conv2d_valid_window: mismatch");
    $finish;
  end
endmodule
